FILE: hw/rtl/wes1d_pkg.sv
// ----------------------------------------------------------------------------
// Wave equation stencil package
// Shared constants, register indexes and the result record of the 1D stencil.
// ----------------------------------------------------------------------------
`default_nettype none

package wes1d_pkg;

  localparam int unsigned MaxCells  = 128;
  localparam int unsigned CellIdxW  = $clog2(MaxCells);
  localparam int unsigned LenW      = CellIdxW + 1;
  localparam int unsigned PressW    = 16;
  localparam int unsigned CourantW  = 16;
  localparam int unsigned RowLenW   = 8;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = FifoPtrW + 1;
  localparam int unsigned PaddrW    = 3;

  typedef enum logic {
    RegCourantSq = 1'b0,
    RegRowLength = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [PressW-1:0] pressure;
    logic [CellIdxW-1:0]      index;
    logic                     row_end;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wave_equation_stencil_1d_core.sv
// ----------------------------------------------------------------------------
// Wave equation stencil, 1D FDTD time step
// Streams one pressure row and returns the next-step pressure of every cell.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in        sink       in_valid_i/in_ready_o   pressure_now_i
//  out       source     out_valid_o/out_ready_i next_pressure_o, cell_index_o, row_end_o
//  cfg       APB slave  psel/penable/pready     courant_sq @0x0, row_length @0x4
//
// One cell is taken per cycle. A cell goes through the input stage and the
// stencil arithmetic into a four-entry result queue, and results leave from
// the queue. The row's last cell pushes two results at once. Input stalls
// only when the queue cannot take the held cell's results. Reset needs no
// clearing pass.
`default_nettype none

module wave_equation_stencil_1d_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [wes1d_pkg::PressW-1:0]   pressure_now_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [wes1d_pkg::PressW-1:0]   next_pressure_o,
  output logic        [wes1d_pkg::CellIdxW-1:0] cell_index_o,
  output logic                                  row_end_o,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic        [wes1d_pkg::PaddrW-1:0]   paddr,
  input  logic        [31:0]                    pwdata,
  output logic        [31:0]                    prdata,
  output logic                                  pready
);

  localparam int unsigned IW = wes1d_pkg::CellIdxW;
  localparam int unsigned PW = wes1d_pkg::PressW;
  localparam int unsigned LW = wes1d_pkg::LenW;

  logic [wes1d_pkg::CourantW-1:0] courant_q;
  logic [wes1d_pkg::RowLenW-1:0]  row_len_q;
  logic                           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      courant_q <= wes1d_pkg::CourantW'(32768);
      row_len_q <= wes1d_pkg::RowLenW'(100);
    end else if (cfg_wr) begin
      if (wes1d_pkg::reg_idx_e'(paddr[2]) == wes1d_pkg::RegCourantSq) begin
        courant_q <= pwdata[wes1d_pkg::CourantW-1:0];
      end else begin
        row_len_q <= pwdata[wes1d_pkg::RowLenW-1:0];
      end
    end
  end

  always_comb begin
    if (wes1d_pkg::reg_idx_e'(paddr[2]) == wes1d_pkg::RegCourantSq) begin
      prdata = 32'(courant_q);
    end else begin
      prdata = 32'(row_len_q);
    end
  end

  // Window and row position, updated at each input transfer.
  logic signed [PW-1:0] left_q, centre_q;
  logic [IW-1:0]        pos_q;
  logic                 first_row_q;
  logic                 pend_valid_q;
  logic [IW-1:0]        pend_addr_q;
  logic signed [PW-1:0] pend_data_q;
  logic signed [PW-1:0] prev_row [wes1d_pkg::MaxCells];

  logic [LW-1:0] len;
  logic          last;
  logic          in_fire;

  always_comb begin
    if (32'(row_len_q) > 32'(wes1d_pkg::MaxCells)) begin
      len = LW'(wes1d_pkg::MaxCells);
    end else if (row_len_q < wes1d_pkg::RowLenW'(3)) begin
      len = LW'(3);
    end else begin
      len = LW'(row_len_q);
    end
    last = {1'b0, pos_q} >= (len - LW'(1));
  end

  // Input stage.
  logic                 s1_valid_q;
  logic signed [PW-1:0] s1_right_q, s1_centre_q, s1_left_q, s1_prev_q;
  logic [IW-1:0]        s1_k_q;
  logic                 s1_last_q, s1_first_q;
  logic                 s1_move;

  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q       <= '0;
      centre_q     <= '0;
      pos_q        <= '0;
      first_row_q  <= 1'b1;
      pend_valid_q <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        left_q   <= centre_q;
        centre_q <= pressure_now_i;
        if (pos_q != '0 && last) begin
          pos_q        <= '0;
          first_row_q  <= 1'b0;
          pend_valid_q <= 1'b1;
        end else begin
          pos_q <= pos_q + IW'(1);
          if (pos_q == '0) begin
            pend_valid_q <= 1'b0;
          end
        end
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_right_q  <= pressure_now_i;
      s1_centre_q <= centre_q;
      s1_left_q   <= left_q;
      s1_k_q      <= pos_q;
      s1_last_q   <= last;
      s1_first_q  <= first_row_q;
      s1_prev_q   <= prev_row[pos_q - IW'(1)];
      if (pos_q != '0) begin
        prev_row[pos_q - IW'(1)] <= centre_q;
        if (last) begin
          pend_addr_q <= pos_q;
          pend_data_q <= pressure_now_i;
        end
      end else if (pend_valid_q) begin
        prev_row[pend_addr_q] <= pend_data_q;
      end
    end
  end

  // Stencil arithmetic.
  logic [16:0]          r2;
  logic signed [17:0]   lap;
  logic signed [34:0]   prod, rnd;
  logic signed [19:0]   scl;
  logic signed [20:0]   sum;
  logic signed [PW-1:0] prev, sat, val;

  always_comb begin
    r2   = (courant_q > 16'd32768) ? 17'd32768 : {1'b0, courant_q};
    prev = s1_first_q ? s1_centre_q : s1_prev_q;
    lap  = 18'(s1_right_q) - 18'(s1_centre_q) - 18'(s1_centre_q) + 18'(s1_left_q);
    prod = 35'(lap) * 35'($signed({1'b0, r2}));
    rnd  = prod + 35'sd16384;
    scl  = 20'(rnd >>> 15);
    sum  = 21'(s1_centre_q) + 21'(s1_centre_q) - 21'(prev) + 21'(scl);
    if (sum > 21'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -21'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[PW-1:0];
    end
    val = (s1_k_q == IW'(1)) ? s1_right_q : sat;
  end

  // Result queue.
  wes1d_pkg::result_t fifo_q [wes1d_pkg::FifoDepth];
  logic [wes1d_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [wes1d_pkg::FifoCntW-1:0] cnt_q, n_push;
  logic                           push0, push1, pop;
  wes1d_pkg::result_t             res0, res1;

  always_comb begin
    push0 = s1_valid_q && (s1_k_q != '0);
    push1 = push0 && s1_last_q;
    n_push = wes1d_pkg::FifoCntW'(push0) + wes1d_pkg::FifoCntW'(push1);
    s1_move = s1_valid_q &&
              (cnt_q <= wes1d_pkg::FifoCntW'(wes1d_pkg::FifoDepth) - n_push);
    res0.pressure = val;
    res0.index    = s1_k_q - IW'(1);
    res0.row_end  = 1'b0;
    res1.pressure = s1_centre_q;
    res1.index    = s1_k_q;
    res1.row_end  = 1'b1;
  end

  assign out_valid_o     = cnt_q != '0;
  assign pop             = out_valid_o && out_ready_i;
  assign next_pressure_o = fifo_q[rd_ptr_q].pressure;
  assign cell_index_o    = fifo_q[rd_ptr_q].index;
  assign row_end_o       = fifo_q[rd_ptr_q].row_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (s1_move) begin
        wr_ptr_q <= wr_ptr_q + n_push[wes1d_pkg::FifoPtrW-1:0];
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + wes1d_pkg::FifoPtrW'(1);
      end
      cnt_q <= cnt_q + (s1_move ? n_push : '0) - wes1d_pkg::FifoCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && push0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (s1_move && push1) begin
      fifo_q[wr_ptr_q + wes1d_pkg::FifoPtrW'(1)] <= res1;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= wes1d_pkg::FifoCntW'(wes1d_pkg::FifoDepth))
    else $error("result queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && pos_q == '0 |=> !pend_valid_q)
    else $error("pending row-end write not retired on first cell");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_k_q))
    else $error("stalled cell lost from input stage");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && pos_q != '0 && last |=> pos_q == '0 && !first_row_q)
    else $error("row did not wrap after its last cell");

endmodule

`default_nettype wire

FILE: dv/tb_wave_equation_stencil_1d_core.sv
// ----------------------------------------------------------------------------
// Testbench for the 1D wave equation stencil core
// Streams pressure rows through the core under random sender gaps and
// receiver stalls, predicts every next-step cell value from its own copy of
// the stencil state and compares each result transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wave_equation_stencil_1d_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned SettleCycles = 10;
  localparam int unsigned ItemTarget = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                                  in_valid_i = 1'b0;
  logic                                  in_ready_o;
  logic signed [wes1d_pkg::PressW-1:0]   pressure_now_i = '0;
  logic                                  out_valid_o;
  logic                                  out_ready_i = 1'b0;
  logic signed [wes1d_pkg::PressW-1:0]   next_pressure_o;
  logic        [wes1d_pkg::CellIdxW-1:0] cell_index_o;
  logic                                  row_end_o;
  logic                                  psel = 1'b0;
  logic                                  penable = 1'b0;
  logic                                  pwrite = 1'b0;
  logic        [wes1d_pkg::PaddrW-1:0]   paddr = '0;
  logic        [31:0]                    pwdata = '0;
  logic        [31:0]                    prdata;
  logic                                  pready;

  wave_equation_stencil_1d_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pressure_now_i (pressure_now_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .next_pressure_o(next_pressure_o),
    .cell_index_o   (cell_index_o),
    .row_end_o      (row_end_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the core's stencil state and registers.
  logic        [wes1d_pkg::CourantW-1:0] courant_q = 16'd32768;
  logic        [wes1d_pkg::RowLenW-1:0]  row_len_q = 8'd100;
  logic signed [wes1d_pkg::PressW-1:0]   last_row [wes1d_pkg::MaxCells];
  logic signed [wes1d_pkg::PressW-1:0]   left_q = '0;
  logic signed [wes1d_pkg::PressW-1:0]   centre_q = '0;
  int unsigned                           cell_pos = 0;
  bit                                    first_row = 1'b1;

  logic signed [wes1d_pkg::PressW-1:0] cell_stream [$];
  wes1d_pkg::result_t                  expected_next_cells [$];
  int unsigned                         mismatches = 0;
  logic signed [wes1d_pkg::PressW-1:0] last_drawn = '0;

  function automatic void advance_stencil(input logic signed [wes1d_pkg::PressW-1:0] right);
    int unsigned                         len;
    int                                  r2;
    int unsigned                         k;
    bit                                  last;
    logic signed [wes1d_pkg::PressW-1:0] prior;
    logic signed [wes1d_pkg::PressW-1:0] val;
    longint                              lap;
    longint                              sum;
    wes1d_pkg::result_t                  res;
    len = row_len_q;
    if (len < 3) len = 3;
    if (len > wes1d_pkg::MaxCells) len = wes1d_pkg::MaxCells;
    r2 = (courant_q > 16'd32768) ? 32768 : int'(courant_q);
    k = (cell_pos >= wes1d_pkg::MaxCells) ? wes1d_pkg::MaxCells - 1 : cell_pos;
    last = (k >= len - 1);
    if (k >= 1) begin
      if (k == 1) begin
        val = right;
      end else begin
        prior = first_row ? centre_q : last_row[k-1];
        lap = longint'(right) - 2 * longint'(centre_q) + longint'(left_q);
        sum = 2 * longint'(centre_q) - longint'(prior) + ((lap * longint'(r2) + 16384) >>> 15);
        if (sum > 32767) val = 16'sh7fff;
        else if (sum < -32768) val = 16'sh8000;
        else val = wes1d_pkg::PressW'(sum);
      end
      last_row[k-1] = centre_q;
      res.pressure = val;
      res.index = wes1d_pkg::CellIdxW'(k - 1);
      res.row_end = 1'b0;
      expected_next_cells.push_back(res);
    end
    if (last && k >= 1) begin
      last_row[k] = right;
      res.pressure = centre_q;
      res.index = wes1d_pkg::CellIdxW'(k);
      res.row_end = 1'b1;
      expected_next_cells.push_back(res);
    end
    left_q = centre_q;
    centre_q = right;
    if (last && k >= 1) begin
      cell_pos = 0;
      first_row = 1'b0;
    end else begin
      cell_pos = k + 1;
    end
  endfunction

  function automatic logic signed [wes1d_pkg::PressW-1:0] draw_pressure();
    logic signed [wes1d_pkg::PressW-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0: v = 16'sh7fff;
          1: v = 16'sh8000;
          default: v = '0;
        endcase
      end
      1, 2, 3: v = wes1d_pkg::PressW'($urandom);
      default: v = last_drawn + wes1d_pkg::PressW'(int'($urandom_range(0, 1023)) - 512);
    endcase
    last_drawn = v;
    return v;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        advance_stencil(pressure_now_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          in_valid_i <= 1'b0;
          gap_left--;
        end else if (cell_stream.size() > 0) begin
          in_valid_i <= 1'b1;
          pressure_now_i <= cell_stream.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall behaviour changes between several patterns.
  int unsigned stall_mode = 0;
  int unsigned mode_left = 50;
  bit          toggle = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    wes1d_pkg::result_t exp_res;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_next_cells.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transfer, expected none, actual %0d/%0d/%0d", $time,
                   next_pressure_o, cell_index_o, row_end_o);
        end else begin
          exp_res = expected_next_cells.pop_front();
          if (exp_res.pressure !== next_pressure_o) begin
            mismatches++;
            $display("%0t: next pressure expected %0d actual %0d (cell %0d)", $time,
                     exp_res.pressure, next_pressure_o, exp_res.index);
          end
          if (exp_res.index !== cell_index_o) begin
            mismatches++;
            $display("%0t: cell_index expected %0d actual %0d", $time, exp_res.index,
                     cell_index_o);
          end
          if (exp_res.row_end !== row_end_o) begin
            mismatches++;
            $display("%0t: row_end expected %0d actual %0d (cell %0d)", $time,
                     exp_res.row_end, row_end_o, exp_res.index);
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      toggle = ~toggle;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= toggle;
      endcase
    end
  end

  // Watchdog on cycles without any transfer.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("%0t: watchdog expired", $time);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input wes1d_pkg::reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      wes1d_pkg::RegCourantSq: courant_q = value[wes1d_pkg::CourantW-1:0];
      wes1d_pkg::RegRowLength: row_len_q = value[wes1d_pkg::RowLenW-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (cell_stream.size() != 0 || in_valid_i || expected_next_cells.size() != 0);
  endtask

  initial begin : stimulus
    logic signed [wes1d_pkg::PressW-1:0] directed [24];
    logic [wes1d_pkg::CourantW-1:0]      cs;
    logic [wes1d_pkg::RowLenW-1:0]       rl;
    int unsigned                         n;
    int unsigned                         sent;
    int unsigned                         phase;
    directed = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                 16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0001,
                 16'shffff, 16'sh5555, 16'shaaaa, 16'sh1000, 16'shf000, 16'sh1000,
                 16'sh0000, 16'shffff, 16'sh7ffe, 16'sh8001, 16'sh7fff, 16'sh8000};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The first row spans every cell so that the whole previous row is known.
    write_reg(wes1d_pkg::RegCourantSq, 32'd32768);
    write_reg(wes1d_pkg::RegRowLength, 32'd128);
    @(negedge clk_i);
    foreach (directed[i]) cell_stream.push_back(directed[i]);
    repeat (wes1d_pkg::MaxCells - 24) cell_stream.push_back(draw_pressure());
    sent = wes1d_pkg::MaxCells;
    phase = 1;
    while (sent < ItemTarget) begin
      wait_idle();
      repeat (SettleCycles) @(posedge clk_i);
      case (phase)
        1: begin cs = 16'd0; rl = 8'd128; n = 50; end
        2: begin cs = 16'hffff; rl = 8'd10; n = 30; end
        3: begin cs = 16'd32769; rl = 8'd0; n = 20; end
        4: begin cs = 16'd32768; rl = 8'd255; n = 40; end
        5: begin cs = 16'd1; rl = 8'd3; n = 12; end
        default: begin
          case ($urandom_range(0, 5))
            0: cs = 16'd0;
            1: cs = 16'd32768;
            2: cs = wes1d_pkg::CourantW'($urandom_range(32769, 65535));
            default: cs = wes1d_pkg::CourantW'($urandom_range(0, 32768));
          endcase
          case ($urandom_range(0, 7))
            0: rl = wes1d_pkg::RowLenW'($urandom_range(0, 2));
            1: rl = 8'd128;
            2: rl = wes1d_pkg::RowLenW'($urandom_range(129, 255));
            3, 4: rl = wes1d_pkg::RowLenW'($urandom_range(3, 12));
            default: rl = wes1d_pkg::RowLenW'($urandom_range(3, 128));
          endcase
          n = $urandom_range(5, 60);
        end
      endcase
      write_reg(wes1d_pkg::RegCourantSq, {16'd0, cs});
      write_reg(wes1d_pkg::RegRowLength, {24'd0, rl});
      @(negedge clk_i);
      repeat (n) cell_stream.push_back(draw_pressure());
      sent += n;
      phase++;
    end
    wait_idle();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
